@@ design/aabb_apo_pkg.sv @@
// ----------------------------------------------------------------------------
// AABB all-pairs overlap package
// Request and record formats, stored box layout and record codes.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_apo_pkg;

    localparam int HANDLE_W = 16;
    localparam int COORD_W  = 32;
    localparam int TOTAL_W  = 11;
    localparam int CAP_W    = 12;

    localparam logic [CAP_W-1:0]   CAP_RESET = 12'd4095;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

    localparam logic KIND_PAIR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0]       object_handle;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic                      last_object;
    } t_in_req;

    typedef struct packed {
        logic                record_kind;
        logic [HANDLE_W-1:0] first_handle;
        logic [HANDLE_W-1:0] second_handle;
        logic [TOTAL_W-1:0]  pair_total;
        logic                result_status;
        logic                last_result;
    } t_out_rec;

    // one stored box
    typedef struct packed {
        logic [HANDLE_W-1:0]       handle;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box_ent;

    // compare unit result
    typedef struct packed {
        logic                valid;
        logic                hit;
        logic [HANDLE_W-1:0] handle;
    } t_cmp_res;

endpackage

`default_nettype wire

@@ design/aabb_apo_cmp.sv @@
// ----------------------------------------------------------------------------
// AABB overlap compare unit
// Registered three-axis overlap test of the new box against one stored box.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_apo_cmp (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  aabb_apo_pkg::t_box_ent   i_new,
    input  aabb_apo_pkg::t_box_ent   i_ref,
    output aabb_apo_pkg::t_cmp_res   o_res
);
    import aabb_apo_pkg::*;

    logic                hit_x;
    logic                hit_y;
    logic                hit_z;
    logic                r_valid;
    logic                r_hit;
    logic [HANDLE_W-1:0] r_handle;

    // touching counts as overlap
    always_comb begin
        hit_x = !((i_ref.max_x < i_new.min_x) || (i_new.max_x < i_ref.min_x));
        hit_y = !((i_ref.max_y < i_new.min_y) || (i_new.max_y < i_ref.min_y));
        hit_z = !((i_ref.max_z < i_new.min_z) || (i_new.max_z < i_ref.min_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit    <= hit_x && hit_y && hit_z;
            r_handle <= i_ref.handle;
        end
    end

    assign o_res = {r_valid, r_hit, r_handle};

endmodule

`default_nettype wire

@@ design/aabb_all_pairs_overlap.sv @@
// ----------------------------------------------------------------------------
// AABB all-pairs overlap finder
// Brute-force broadphase: each new box is tested against all stored boxes.
// ----------------------------------------------------------------------------
// Input channel: one box request per accept (i_in_valid high, o_in_stall low).
// o_in_stall is high from the accept until every record of that request has
// been handed to the output register. Output channel: o_out_valid with
// i_out_stall; a held record stays unchanged while stalled, and the scan
// pipeline freezes until the output register frees up.
// Per request the box store is read one entry a cycle while the output
// register is free, through a single read port and a shared three-axis
// compare unit; the input stays stalled over the scan of the stored boxes
// and, when the request is marked last, over the summary. With a full
// store the box is dropped. Pair records come out one record late inside a
// request (a held record waits to learn whether it is the final one): a
// held record leaves with the next match, the final one when the scan ends.
// Records for a later box follow those of the earlier one.
// Capacity (i_cfg_wdata on i_cfg_we) must be written only while idle; the block does not enforce it.
// Reset empties the set, zeroes the pair count, sets capacity to 4095 and
// drops any record in flight. The box store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_all_pairs_overlap #(
    parameter int MAX_BOXES = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  aabb_apo_pkg::t_in_req                i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output aabb_apo_pkg::t_out_rec               o_out_data,
    input  wire                                  i_cfg_we,
    input  wire [aabb_apo_pkg::CAP_W-1:0]        i_cfg_wdata
);
    import aabb_apo_pkg::*;

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    t_box_ent mem [MAX_BOXES];

    logic [1:0]         r_state;
    logic [CAP_W-1:0]   r_cap;
    logic [CW-1:0]      r_box_count;
    logic [CW-1:0]      r_n_cmp;
    logic [CW-1:0]      r_rd_idx;
    logic [TOTAL_W-1:0] r_pair_cnt;
    logic               r_last;
    logic               r_v1;
    logic               r_pend_valid;
    logic               r_out_valid;
    t_box_ent           r_box;
    t_box_ent           r_rd;
    t_out_rec           r_pend;
    t_out_rec           r_out;

    t_box_ent           new_ent;
    t_cmp_res           cmp_res;
    t_out_rec           n_out;
    logic               out_free;
    logic               in_acc;
    logic               full;
    logic               issue;
    logic               scan_done;
    logic               pair_hit;
    logic               pair_emit;
    logic               ld_out_pend;
    logic               ld_out_sum;

    always_comb begin
        new_ent.handle = i_in_data.object_handle;
        new_ent.min_x  = i_in_data.min_x;
        new_ent.min_y  = i_in_data.min_y;
        new_ent.min_z  = i_in_data.min_z;
        new_ent.max_x  = i_in_data.max_x;
        new_ent.max_y  = i_in_data.max_y;
        new_ent.max_z  = i_in_data.max_z;

        out_free   = !r_out_valid || !i_out_stall;
        o_in_stall = (r_state != ST_IDLE);
        in_acc     = i_in_valid && !o_in_stall;
        full       = (r_box_count == CW'(MAX_BOXES));
        issue      = (r_state == ST_SCAN) && (r_rd_idx < r_n_cmp);
        scan_done  = (r_state == ST_SCAN) && !issue && !r_v1 && !cmp_res.valid;

        pair_hit   = (r_state == ST_SCAN) && out_free && cmp_res.valid && cmp_res.hit;
        pair_emit  = pair_hit && ({1'b0, r_pair_cnt} < r_cap);
        ld_out_pend = (pair_emit && r_pend_valid)
                   || ((r_state == ST_FLUSH) && r_pend_valid && out_free);
        ld_out_sum  = (r_state == ST_SUM) && out_free;

        if (ld_out_sum) begin
            n_out.record_kind   = KIND_SUMMARY;
            n_out.first_handle  = '0;
            n_out.second_handle = '0;
            n_out.pair_total    = r_pair_cnt;
            n_out.result_status = ({1'b0, r_pair_cnt} > r_cap) ? STATUS_SHORT : STATUS_OK;
            n_out.last_result   = 1'b1;
        end else begin
            n_out             = r_pend;
            // held record is final only when flushed and no summary follows
            n_out.last_result = (r_state == ST_FLUSH) && !r_last;
        end
    end

    // box store: one write on accept while not full, one registered read per scan step
    always_ff @(posedge i_clk) begin
        if (in_acc && !full) begin
            mem[r_box_count[IW-1:0]] <= new_ent;
        end
        if (out_free) begin
            r_rd <= mem[r_rd_idx[IW-1:0]];
        end
    end

    aabb_apo_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (out_free),
        .i_valid (r_v1),
        .i_new   (r_box),
        .i_ref   (r_rd),
        .o_res   (cmp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cap        <= CAP_RESET;
            r_box_count  <= '0;
            r_n_cmp      <= '0;
            r_rd_idx     <= '0;
            r_pair_cnt   <= '0;
            r_last       <= 1'b0;
            r_v1         <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end

            if (ld_out_pend || ld_out_sum) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_last   <= i_in_data.last_object;
                        r_rd_idx <= '0;
                        if (!full) begin
                            r_n_cmp     <= r_box_count;
                            r_box_count <= r_box_count + CW'(1);
                        end else begin
                            r_n_cmp <= '0;
                        end
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (out_free) begin
                        r_v1 <= issue;
                        if (issue) begin
                            r_rd_idx <= r_rd_idx + CW'(1);
                        end
                    end
                    if (pair_emit) begin
                        r_pend_valid <= 1'b1;
                    end
                    if (pair_hit && (r_pair_cnt != TOTAL_MAX)) begin
                        r_pair_cnt <= r_pair_cnt + TOTAL_W'(1);
                    end
                    if (scan_done) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid || out_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= r_last ? ST_SUM : ST_IDLE;
                    end
                end
                ST_SUM: begin
                    if (out_free) begin
                        r_box_count <= '0;
                        r_pair_cnt  <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_box <= new_ent;
        end
        if (pair_emit) begin
            r_pend.record_kind   <= KIND_PAIR;
            r_pend.first_handle  <= cmp_res.handle;
            r_pend.second_handle <= r_box.handle;
            r_pend.pair_total    <= '0;
            r_pend.result_status <= STATUS_OK;
            r_pend.last_result   <= 1'b0;
        end
        if (ld_out_pend || ld_out_sum) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pend_empty_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held pair record left over at end of request");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_box_count <= CW'(MAX_BOXES))
        else $error("box count beyond store depth");

    a_read_in_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || cmp_res.valid) |-> (r_state == ST_SCAN))
        else $error("scan pipeline busy outside scan");

    a_summary_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SUM) && out_free) |=>
        (o_out_valid && (o_out_data.record_kind == KIND_SUMMARY)
         && o_out_data.last_result && (r_box_count == '0)))
        else $error("summary record not issued or set not cleared");

    a_idx_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rd_idx <= r_n_cmp))
        else $error("scan index ran past stored count");

endmodule

`default_nettype wire

@@ dv/aabb_apo_checker.sv @@
// ----------------------------------------------------------------------------
// AABB all-pairs overlap checker
// Watches the request, record and capacity ports. For every accepted request
// it predicts the pair and summary records, then compares the records leaving
// the block, in order and field by field, against that prediction.
// ----------------------------------------------------------------------------
module aabb_apo_checker #(
    parameter int MAX_BOXES = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    input  wire                           i_in_stall,
    input  aabb_apo_pkg::t_in_req         i_in_data,
    input  wire                           i_out_valid,
    input  wire                           i_out_stall,
    input  aabb_apo_pkg::t_out_rec        i_out_data,
    input  wire                           i_cfg_we,
    input  wire [aabb_apo_pkg::CAP_W-1:0] i_cfg_wdata,
    input  wire                           i_end_check,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_records_checked
);

    import aabb_apo_pkg::*;

    t_box_ent           set_boxes [MAX_BOXES];
    int                 boxes_held;
    logic [TOTAL_W-1:0] overlaps_found;
    logic [CAP_W-1:0]   pair_capacity;
    t_out_rec           due_records [$];
    int                 fail_total    = 0;
    int                 checked_total = 0;
    logic               end_done      = 1'b0;

    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $time, what);
        fail_total++;
    endtask

    // touching faces count as overlap; inverted boxes take the same rule
    function automatic logic boxes_touch(input t_box_ent a, input t_in_req b);
        return !($signed(a.max_x) < $signed(b.min_x) || $signed(b.max_x) < $signed(a.min_x))
            && !($signed(a.max_y) < $signed(b.min_y) || $signed(b.max_y) < $signed(a.min_y))
            && !($signed(a.max_z) < $signed(b.min_z) || $signed(b.max_z) < $signed(a.min_z));
    endfunction

    task automatic predict_box(input t_in_req req);
        t_out_rec rec;
        t_out_rec batch [$];
        if (boxes_held < MAX_BOXES) begin
            for (int i = 0; i < boxes_held; i++) begin
                if (boxes_touch(set_boxes[i], req)) begin
                    if (overlaps_found < pair_capacity) begin
                        rec               = '0;
                        rec.record_kind   = KIND_PAIR;
                        rec.first_handle  = set_boxes[i].handle;
                        rec.second_handle = req.object_handle;
                        batch.push_back(rec);
                    end
                    if (overlaps_found != TOTAL_MAX) overlaps_found++;
                end
            end
            set_boxes[boxes_held] = '{handle: req.object_handle,
                                      min_x: req.min_x, min_y: req.min_y, min_z: req.min_z,
                                      max_x: req.max_x, max_y: req.max_y, max_z: req.max_z};
            boxes_held++;
        end
        // a full set drops the box, but its last mark still closes the set
        if (req.last_object) begin
            rec               = '0;
            rec.record_kind   = KIND_SUMMARY;
            rec.pair_total    = overlaps_found;
            rec.result_status = (overlaps_found > pair_capacity) ? STATUS_SHORT : STATUS_OK;
            batch.push_back(rec);
            boxes_held     = 0;
            overlaps_found = '0;
        end
        if (batch.size() > 0) batch[batch.size()-1].last_result = 1'b1;
        foreach (batch[k]) due_records.push_back(batch[k]);
    endtask

    task automatic check_record(input t_out_rec got);
        t_out_rec want;
        if (due_records.size() == 0) begin
            report_mismatch($sformatf("record kind %0d handles %h/%h total %0d with none due",
                                      got.record_kind, got.first_handle, got.second_handle,
                                      got.pair_total));
            return;
        end
        want = due_records.pop_front();
        checked_total++;
        if (got.record_kind !== want.record_kind)
            report_mismatch($sformatf("record %0d record_kind: got %0d, due %0d",
                                      checked_total, got.record_kind, want.record_kind));
        if (got.first_handle !== want.first_handle)
            report_mismatch($sformatf("record %0d first_handle: got %h, due %h",
                                      checked_total, got.first_handle, want.first_handle));
        if (got.second_handle !== want.second_handle)
            report_mismatch($sformatf("record %0d second_handle: got %h, due %h",
                                      checked_total, got.second_handle, want.second_handle));
        if (got.pair_total !== want.pair_total)
            report_mismatch($sformatf("record %0d pair_total: got %0d, due %0d",
                                      checked_total, got.pair_total, want.pair_total));
        if (got.result_status !== want.result_status)
            report_mismatch($sformatf("record %0d result_status: got %0d, due %0d",
                                      checked_total, got.result_status, want.result_status));
        if (got.last_result !== want.last_result)
            report_mismatch($sformatf("record %0d last_result: got %0d, due %0d",
                                      checked_total, got.last_result, want.last_result));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            boxes_held     = 0;
            overlaps_found = '0;
            pair_capacity  = CAP_RESET;
            due_records.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_record(i_out_data);
            if (i_cfg_we) pair_capacity = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predict_box(i_in_data);
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (due_records.size() != 0)
                    report_mismatch($sformatf("%0d records never arrived", due_records.size()));
            end
        end
        o_fail_count      <= fail_total;
        o_pending         <= due_records.size();
        o_records_checked <= checked_total;
    end

endmodule

@@ dv/aabb_all_pairs_overlap_tb.sv @@
// ----------------------------------------------------------------------------
// AABB all-pairs overlap testbench
// Drives box requests in detection sets under several pair capacities, with
// random gaps and record back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module aabb_all_pairs_overlap_tb;

    import aabb_apo_pkg::*;

    localparam int MAX_BOXES      = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 3000;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_in_req          i_in_data   = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_rec         o_out_data;

    int   fail_count;
    int   records_pending;
    int   records_checked;
    logic check_end     = 1'b0;
    logic hold_req      = 1'b0;
    logic send_idle_on  = 1'b1;
    logic stall_idle_on = 1'b1;
    int   boxes_sent    = 0;
    int   sets_sent     = 0;
    int   settings_used = 0;

    aabb_all_pairs_overlap #(
        .MAX_BOXES (MAX_BOXES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    aabb_apo_checker #(
        .MAX_BOXES (MAX_BOXES)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_in_data         (i_in_data),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_out_data        (o_out_data),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_end_check       (check_end),
        .o_fail_count      (fail_count),
        .o_pending         (records_pending),
        .o_records_checked (records_checked)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_in_req make_box(input logic [HANDLE_W-1:0] h,
                                         input logic [COORD_W-1:0] lx, ly, lz, hx, hy, hz,
                                         input logic last);
        t_in_req b;
        b.object_handle = h;
        b.min_x         = lx;
        b.min_y         = ly;
        b.min_z         = lz;
        b.max_x         = hx;
        b.max_y         = hy;
        b.max_z         = hz;
        b.last_object   = last;
        return b;
    endfunction

    function automatic t_in_req cube(input logic [HANDLE_W-1:0] h,
                                     input logic [COORD_W-1:0] lo, hi, input logic last);
        return make_box(h, lo, lo, lo, hi, hi, hi, last);
    endfunction

    // mostly clustered boxes around the set base, some raw noise, some inverted
    function automatic t_in_req random_box(input logic last, input logic [COORD_W-1:0] base);
        logic [COORD_W-1:0] lo [3];
        logic [COORD_W-1:0] hi [3];
        logic [COORD_W-1:0] tmp;
        int                 mode;
        int                 flip;
        mode = $urandom_range(0, 99);
        flip = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++) begin
            if (mode >= 70 && mode < 85) begin
                lo[a] = $urandom();
                hi[a] = $urandom();
            end else begin
                lo[a] = base + $urandom_range(0, 32'h0006_0000);
                hi[a] = lo[a] + $urandom_range(0, 32'h0004_0000);
            end
        end
        if (mode >= 85) begin
            tmp      = lo[flip];
            lo[flip] = hi[flip];
            hi[flip] = tmp;
        end
        return make_box(HANDLE_W'($urandom_range(0, 65535)),
                        lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], last);
    endfunction

    task automatic send_box(input t_in_req req);
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        boxes_sent++;
        if (req.last_object) sets_sent++;
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // sender waits until every due record is out, then lets a silent scan finish
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (records_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_sets(input int n_items, input logic with_full_set);
        int                 left;
        int                 len;
        logic               full_pending;
        logic [COORD_W-1:0] base;
        left         = n_items;
        full_pending = with_full_set;
        while (left > 0) begin
            len          = full_pending ? MAX_BOXES + 3 : $urandom_range(1, 10);
            full_pending = 1'b0;
            if (len > left) len = left;
            base = $urandom();
            for (int k = 0; k < len; k++) send_box(random_box(k == len - 1, base));
            left -= len;
        end
    endtask

    initial begin : record_receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req    <= 1'b0;
            end else if (stall_idle_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("aabb_all_pairs_overlap regression: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_capacity(CAP_RESET);

        // extremes of space, touching corners and faces, a near miss, an inverted box
        send_box(cube(16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_box(cube(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_box(cube(16'h1234, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_box(cube(16'h0005, 32'h0000_0000, 32'h0001_0000, 1'b0));
        send_box(make_box(16'h0006, 32'h0001_0000, 32'h0, 32'h0,
                          32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
        send_box(make_box(16'h0007, 32'h0001_0001, 32'h0, 32'h0,
                          32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
        send_box(make_box(16'h0008, 32'h0002_0000, 32'h0, 32'h0,
                          32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
        send_box(cube(16'hABCD, 32'h4000_0000, 32'h4000_0000, 1'b1));
        // lone last box: summary with nothing found
        send_box(cube(16'h0042, 32'h0000_0000, 32'h0001_0000, 1'b1));
        settle_idle();

        // zero capacity: only the summary, marked short
        write_capacity('0);
        send_box(cube(16'h0001, 32'h0000_0000, 32'h0001_0000, 1'b0));
        send_box(cube(16'h0002, 32'h0000_0000, 32'h0001_0000, 1'b0));
        send_box(cube(16'h0003, 32'h0000_0000, 32'h0001_0000, 1'b1));
        settle_idle();

        // capacity one: third box finds pairs only past capacity
        write_capacity(12'd1);
        send_box(cube(16'h0010, 32'h0000_0000, 32'h0001_0000, 1'b0));
        send_box(cube(16'h0011, 32'h0000_0000, 32'h0001_0000, 1'b0));
        send_box(cube(16'h0012, 32'h0000_0000, 32'h0001_0000, 1'b0));
        send_box(cube(16'h0013, 32'h0005_0000, 32'h0006_0000, 1'b1));
        settle_idle();

        // full capacity with a long record hold-off and an over-full set
        write_capacity(CAP_RESET);
        hold_req <= 1'b1;
        send_random_sets(45, 1'b1);
        settle_idle();

        write_capacity(CAP_W'($urandom_range(2, 12)));
        send_random_sets(25, 1'b0);
        settle_idle();

        write_capacity('0);
        send_random_sets(15, 1'b0);
        settle_idle();

        // closing stretch runs without any idling
        write_capacity(CAP_W'($urandom_range(1, 40)));
        send_idle_on  = 1'b0;
        stall_idle_on = 1'b0;
        send_random_sets(20, 1'b0);
        settle_idle();

        check_end <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("covered %0d boxes in %0d sets over %0d capacity writes, %0d records checked",
                 boxes_sent, sets_sent, settings_used, records_checked);
        $display("incl. touching and inverted boxes, a full set, zero and small capacities");
        if (fail_count == 0) begin
            $display("aabb_all_pairs_overlap regression: pass");
        end else begin
            $display("aabb_all_pairs_overlap regression: fail");
        end
        $finish;
    end

endmodule
